>>> hw/rtl/mwo_pkg.sv
package mwo_pkg;

    // Waveform selection codes held in the wave_type register.
    typedef enum logic [2:0] {
        SHAPE_SINE     = 3'd0,
        SHAPE_SQUARE   = 3'd1,
        SHAPE_TRIANGLE = 3'd2,
        SHAPE_SAWTOOTH = 3'd3,
        SHAPE_NOISE    = 3'd4
    } wave_t;

    // Register indexes on the configuration port (byte address is four times this).
    localparam logic [1:0] REG_WAVE_TYPE    = 2'd0;
    localparam logic [1:0] REG_PHASE_STEP   = 2'd1;
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd2;
    localparam logic [1:0] REG_NOISE_SEED   = 2'd3;

    // Full-scale sample magnitude and its negative.
    localparam logic [14:0]        FULL_SCALE     = 15'd32767;
    localparam logic signed [15:0] POS_FULL_SCALE = 16'sd32767;
    localparam logic signed [15:0] NEG_FULL_SCALE = -16'sd32767;

    // Half pi in Q30, the seed of the quarter-wave sine series.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Galois noise generator feedback mask.
    localparam logic [31:0] LFSR_TOGGLE = 32'hD000_0001;

    // Shaped value handed from the wave shaper to the top level.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               type_error;
    } wave_out_t;

    // One result word as it sits in the output or skid register.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
        logic               type_error;
    } rsp_t;

endpackage

>>> hw/rtl/mwo_sine_rom.sv
module mwo_sine_rom
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] index,
    output logic [14:0]                         value
);

    logic [14:0] rom [SINE_TABLE_DEPTH];

    // Each entry is a Q30 Taylor series of sin at the center of its slot,
    // evaluated entirely at elaboration.
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * SINE_TABLE_DEPTH);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
        localparam logic [63:0] S1 = (X >= T1) ? X - T1 : 64'd0;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] S2 = S1 + T2;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] S3 = (S2 >= T3) ? S2 - T3 : 64'd0;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] S4 = S3 + T4;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] S5 = (S4 >= T5) ? S4 - T5 : 64'd0;
        localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
        localparam logic [63:0] S6 = S5 + T6;
        localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
        localparam logic [63:0] S7 = (S6 >= T7) ? S6 - T7 : 64'd0;
        localparam logic [63:0] T8 = ((T7 * X2) >> 30) / 64'd272;
        localparam logic [63:0] S8 = S7 + T8;
        localparam logic [63:0] V  = (S8 * 64'(FULL_SCALE)) >> 30;
        localparam logic [63:0] E  = (V > 64'(FULL_SCALE)) ? 64'(FULL_SCALE) : V;
        assign rom[k] = E[14:0];
    end

    // Table read.
    assign value = rom[index];

endmodule

>>> hw/rtl/mwo_wave_shaper.sv
module mwo_wave_shaper
    import mwo_pkg::*;
#(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic [2:0]            wave_type,
    input  logic [PHASE_BITS-1:0] phase,
    input  logic [15:0]           noise_top,
    output wave_out_t             wave
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int FRAC_W = PHASE_BITS - 2;
    localparam int W      = PHASE_BITS + 2;

    localparam logic [W-1:0]          FULL       = W'(1) << PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] TRI_OFFSET = {2'b11, {FRAC_W{1'b0}}};

    // 32767 * mag / 2^P truncated, then signed; mag never exceeds 2^P.
    function automatic logic signed [15:0] scale(input logic neg, input logic [W-1:0] mag);
        logic [W+14:0] prod;
        logic [14:0]   r;
        prod = {mag, 15'd0} - (W+15)'(mag);
        r    = prod[PHASE_BITS +: 15];
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

    logic [FRAC_W+IDX_W-1:0] idx_prod;
    logic [IDX_W-1:0]        idx_raw;
    logic [IDX_W-1:0]        idx;
    logic [14:0]             sine_mag;
    logic signed [15:0]      sine_val;
    logic [W-1:0]            two_p;
    logic [W-1:0]            two_q;
    logic [W-1:0]            tri_d;
    logic [W-1:0]            tri_n;
    logic [PHASE_BITS-1:0]   tri_q;
    logic signed [15:0]      saw_val;
    logic signed [15:0]      tri_val;
    logic signed [15:0]      noise_val;

    // Quarter-wave table address, mirrored in the second and fourth quadrants.
    assign idx_prod = (FRAC_W+IDX_W)'(phase[FRAC_W-1:0]) * (FRAC_W+IDX_W)'(SINE_TABLE_DEPTH);
    assign idx_raw  = idx_prod[FRAC_W +: IDX_W];
    assign idx      = phase[FRAC_W] ? IDX_W'(SINE_TABLE_DEPTH - 1) - idx_raw : idx_raw;

    mwo_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .index(idx),
        .value(sine_mag)
    );

    // The lower half of the cycle is positive.
    assign sine_val = phase[PHASE_BITS-1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

    // Sawtooth rises from minus full scale across the cycle.
    assign two_p   = W'(phase) << 1;
    assign saw_val = (two_p >= FULL) ? scale(1'b0, two_p - FULL) : scale(1'b1, FULL - two_p);

    // Triangle is a folded sawtooth of the phase shifted by three quarters.
    assign tri_q   = phase + TRI_OFFSET;
    assign two_q   = W'(tri_q) << 1;
    assign tri_d   = (two_q >= FULL) ? two_q - FULL : FULL - two_q;
    assign tri_n   = tri_d << 1;
    assign tri_val = (tri_n >= FULL) ? scale(1'b0, tri_n - FULL) : scale(1'b1, FULL - tri_n);

    // Noise is the top half of the generator, kept symmetric.
    assign noise_val = (noise_top == 16'h8000) ? NEG_FULL_SCALE : $signed(noise_top);

    // Waveform selection.
    always_comb
    begin
        wave.type_error = 1'b0;
        unique case (wave_type)
            SHAPE_SINE:     wave.sample = sine_val;
            SHAPE_SQUARE:   wave.sample = phase[PHASE_BITS-1] ? NEG_FULL_SCALE : POS_FULL_SCALE;
            SHAPE_TRIANGLE: wave.sample = tri_val;
            SHAPE_SAWTOOTH: wave.sample = saw_val;
            SHAPE_NOISE:    wave.sample = noise_val;
            default:
            begin
                wave.sample     = 16'sd0;
                wave.type_error = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/multi_waveform_oscillator.sv
// Phase-accumulator waveform generator. Every word accepted on the req channel is one tick and
// yields exactly one result word on the rsp channel. The whole sample is formed in a single pass
// from the phase register to the output register, and a skid register absorbs a word when rsp is
// stalled; a new tick can be taken every clock while the skid register is empty.
// Registers on the APB port: 0x0 wave_type (sine, square, triangle, sawtooth, noise; other
// codes give zero and raise type_error), 0x4 phase_step (0.32 fraction of a cycle per tick),
// 0x8 sample_count (samples per buffer; the final one raises last_sample and the phase and
// index restart), 0xC noise_seed (loaded into the 32-bit noise generator on restart, zero acts
// as one). A tick with restart set clears phase and index and reloads the noise generator
// before its sample is formed. Write registers only while no tick is in flight.
module multi_waveform_oscillator
    import mwo_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 32,
    parameter int COUNT_BITS       = 24
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               req_valid,
    output logic               req_ready,
    input  logic               restart,

    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [15:0] sample,
    output logic               last_sample,
    output logic               type_error
);

    localparam int CMP_W = ((COUNT_BITS > 24) ? COUNT_BITS : 24) + 1;

    logic [2:0]            wave_type_reg;
    logic [31:0]           phase_step_reg;
    logic [23:0]           sample_count_reg;
    logic [31:0]           noise_seed_reg;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [COUNT_BITS-1:0] index_reg;
    logic [COUNT_BITS-1:0] index_next;
    logic [31:0]           noise_reg;
    logic [31:0]           noise_next;

    rsp_t                  out_reg;
    rsp_t                  out_next;
    logic                  out_valid_reg;
    rsp_t                  skid_reg;
    logic                  skid_valid_reg;

    logic                  cfg_write;
    logic                  req_accept;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [COUNT_BITS-1:0] index_cur;
    logic [31:0]           noise_cur;
    logic [PHASE_BITS+31:0] step_wide;
    logic [PHASE_BITS-1:0] step_aligned;
    logic                  last_now;
    wave_out_t             wave;

    // Configuration port: zero-wait writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg    <= SHAPE_SINE;
            phase_step_reg   <= 32'd0;
            sample_count_reg <= 24'd1;
            noise_seed_reg   <= 32'd1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_WAVE_TYPE:    wave_type_reg    <= pwdata[2:0];
                REG_PHASE_STEP:   phase_step_reg   <= pwdata;
                REG_SAMPLE_COUNT: sample_count_reg <= pwdata[23:0];
                REG_NOISE_SEED:   noise_seed_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WAVE_TYPE:    prdata = {29'd0, wave_type_reg};
            REG_PHASE_STEP:   prdata = phase_step_reg;
            REG_SAMPLE_COUNT: prdata = {8'd0, sample_count_reg};
            REG_NOISE_SEED:   prdata = noise_seed_reg;
            default:          prdata = 32'd0;
        endcase
    end

    // Input side is held off only while the skid register is occupied.
    assign req_ready  = !skid_valid_reg;
    assign req_accept = req_valid && req_ready;

    // State seen by this tick, after an optional restart.
    assign phase_cur = restart ? '0 : phase_reg;
    assign index_cur = restart ? '0 : index_reg;
    assign noise_cur = restart ? ((noise_seed_reg != 32'd0) ? noise_seed_reg : 32'd1) : noise_reg;

    // End of buffer, counting a zero sample count as one.
    assign last_now = (CMP_W'(index_cur) + CMP_W'(1)) >= CMP_W'(sample_count_reg);

    // The step register is a 0.32 fraction, realigned to the phase width.
    assign step_wide    = {phase_step_reg, {PHASE_BITS{1'b0}}};
    assign step_aligned = step_wide[PHASE_BITS+31:32];

    mwo_wave_shaper #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_wave_shaper (
        .wave_type(wave_type_reg),
        .phase    (phase_cur),
        .noise_top(noise_cur[31:16]),
        .wave     (wave)
    );

    // Next oscillator state.
    always_comb
    begin
        noise_next = (noise_cur >> 1) ^ (noise_cur[0] ? LFSR_TOGGLE : 32'd0);
        if (last_now)
        begin
            phase_next = '0;
            index_next = '0;
        end
        else
        begin
            phase_next = phase_cur + step_aligned;
            index_next = index_cur + COUNT_BITS'(1);
        end
        out_next.sample      = wave.sample;
        out_next.last_sample = last_now;
        out_next.type_error  = wave.type_error;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            index_reg <= '0;
            noise_reg <= 32'd1;
        end
        else if (req_accept)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            noise_reg <= noise_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp_ready)
        begin
            out_valid_reg  <= skid_valid_reg || req_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (req_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rsp_ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : out_next;
        end
        else if (req_accept)
        begin
            skid_reg <= out_next;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign sample      = out_reg.sample;
    assign last_sample = out_reg.last_sample;
    assign type_error  = out_reg.type_error;

`ifndef SYNTHESIS
    // A word waits in the skid register only behind a word in the output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    // A tick accepted against a stalled output must land in the skid register.
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && out_valid_reg && !rsp_ready) |=> skid_valid_reg)
        else $error("word accepted during a stall was not kept");

    // The final sample of a buffer sends phase and index back to the start.
    a_buffer_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && last_now) |=> (phase_reg == '0 && index_reg == '0))
        else $error("phase or index did not restart after the last sample");

    // The noise generator never reaches the all-zero lockup state.
    a_noise_alive: assert property (@(posedge clk) disable iff (!rst_n)
        noise_reg != 32'd0)
        else $error("noise generator locked at zero");
`endif

endmodule

>>> tb/multi_waveform_oscillator_tb.sv
module multi_waveform_oscillator_tb;
    import mwo_pkg::*;

    localparam int SINE_DEPTH   = 256;
    localparam int RANDOM_TICKS = 880;
    localparam int CYCLE_LIMIT  = 400000;

    // Wave codes outside the package enum; these give silence and raise type_error.
    localparam logic [2:0] SHAPE_SILENT_FIRST = 3'd5;
    localparam logic [2:0] SHAPE_SILENT_LAST  = 3'd7;

    // One row of the directed sequence: a register write or a tick.
    typedef struct {
        bit          cfg;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        bit          restart;
        bit          typed;
        rsp_t        word;
    } stim_row_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [3:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               req_valid   = 1'b0;
    logic               req_ready;
    logic               restart     = 1'b0;
    logic               rsp_valid;
    logic               rsp_ready   = 1'b1;
    logic signed [15:0] sample;
    logic               last_sample;
    logic               type_error;

    // Shadow of the oscillator state and its registers.
    logic [14:0] quarter_sine [SINE_DEPTH];
    logic [31:0] osc_phase  = '0;
    logic [23:0] osc_index  = '0;
    logic [31:0] noise_lfsr = 32'd1;
    logic [2:0]  cfg_wave   = SHAPE_SINE;
    logic [31:0] cfg_step   = '0;
    logic [23:0] cfg_count  = 24'd1;
    logic [31:0] cfg_seed   = 32'd1;

    rsp_t pending_words [$];
    rsp_t oldest_word;
    int   error_count = 0;
    int   cycle_count = 0;
    bit   idle_on     = 1'b1;

    multi_waveform_oscillator dut (.*);

    always #2 clk = ~clk;

    // Quarter-wave sine constants from the Q30 Taylor series, truncated to full scale.
    initial
    begin : quarter_sine_build
        longint unsigned x, x2, term, acc, v;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            x = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * SINE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            acc = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
                if (n % 2 == 1)
                    acc = (acc >= term) ? acc - term : 64'd0;
                else
                    acc = acc + term;
            end
            v = (acc * 64'(FULL_SCALE)) >> 30;
            if (v > 64'(FULL_SCALE))
                v = 64'(FULL_SCALE);
            quarter_sine[k] = v[14:0];
        end
    end

    // Work out the word for one tick and advance the shadow state.
    function automatic rsp_t osc_next_word(input bit rst_bit);
        rsp_t            w;
        longint unsigned full, span, fold;
        logic [31:0]     q;
        logic [7:0]      ti;
        logic [15:0]     top;
        int              val;
        bit              ramp;
        bit              end_buf;
        if (rst_bit)
        begin
            osc_phase = '0;
            osc_index = '0;
            noise_lfsr = (cfg_seed != 32'd0) ? cfg_seed : 32'd1;
        end
        full = 64'd1 << 32;
        w.type_error = 1'b0;
        val = 0;
        ramp = 1'b0;
        span = 0;
        case (cfg_wave)
            SHAPE_SINE:
            begin
                ti = osc_phase[29:22];
                if (osc_phase[30])
                    ti = ~ti;
                val = int'(quarter_sine[ti]);
                if (osc_phase[31])
                    val = -val;
            end
            SHAPE_SQUARE:
                val = osc_phase[31] ? int'(NEG_FULL_SCALE) : int'(POS_FULL_SCALE);
            SHAPE_TRIANGLE:
            begin
                // A quarter-cycle lag turns the folded ramp into a triangle starting at zero.
                q = osc_phase + 32'hC000_0000;
                span = 64'(q) << 1;
                fold = (span >= full) ? span - full : full - span;
                span = fold << 1;
                ramp = 1'b1;
            end
            SHAPE_SAWTOOTH:
            begin
                span = 64'(osc_phase) << 1;
                ramp = 1'b1;
            end
            SHAPE_NOISE:
            begin
                top = noise_lfsr[31:16];
                val = (top == 16'h8000) ? int'(NEG_FULL_SCALE) : int'($signed(top));
            end
            default:
                w.type_error = 1'b1;
        endcase
        // Ramps are scaled from (span - full) / full, truncated toward zero.
        if (ramp)
        begin
            if (span >= full)
                val = int'(((span - full) * 64'(FULL_SCALE)) >> 32);
            else
                val = -int'(((full - span) * 64'(FULL_SCALE)) >> 32);
        end
        end_buf = ({1'b0, osc_index} + 25'd1) >= {1'b0, cfg_count};
        w.sample = 16'(val);
        w.last_sample = end_buf;
        // The noise generator runs on every tick, whatever the wave.
        if (noise_lfsr[0])
            noise_lfsr = (noise_lfsr >> 1) ^ LFSR_TOGGLE;
        else
            noise_lfsr = noise_lfsr >> 1;
        if (end_buf)
        begin
            osc_phase = '0;
            osc_index = '0;
        end
        else
        begin
            osc_phase = osc_phase + cfg_step;
            osc_index = osc_index + 24'd1;
        end
        return w;
    endfunction

    function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
        return '{1'b1, idx, val, 1'b0, 1'b0, rsp_t'(0)};
    endfunction

    function automatic stim_row_t tick_row(input bit rst_bit);
        return '{1'b0, '0, '0, rst_bit, 1'b0, rsp_t'(0)};
    endfunction

    function automatic stim_row_t known_row(input bit rst_bit, input logic signed [15:0] s,
                                            input bit l, input bit e);
        rsp_t w;
        w.sample = s;
        w.last_sample = l;
        w.type_error = e;
        return '{1'b0, '0, '0, rst_bit, 1'b1, w};
    endfunction

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WAVE_TYPE:    cfg_wave = val[2:0];
            REG_PHASE_STEP:   cfg_step = val;
            REG_SAMPLE_COUNT: cfg_count = val[23:0];
            REG_NOISE_SEED:   cfg_seed = val;
            default:          ;
        endcase
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Offer one tick, possibly after a random gap, and log its expected word on acceptance.
    task automatic send_tick(input bit rst_bit, input bit typed, input rsp_t typed_word);
        rsp_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_valid <= 1'b1;
        restart <= rst_bit;
        do @(posedge clk); while (!req_ready);
        predicted = osc_next_word(rst_bit);
        pending_words.push_back(typed ? typed_word : predicted);
    endtask

    // Receiver stalls in random bursts while idling is on.
    initial
    begin : rsp_stall_gen
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                if (hold == 0)
                    rsp_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                hold = $urandom_range(1, 14);
                rsp_ready <= 1'b0;
            end
        end
    end

    // Compare each returned word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: word with no tick pending: sample %0d last %0b error %0b",
                         $time, sample, last_sample, type_error);
                error_count++;
            end
            else
            begin
                oldest_word = pending_words.pop_front();
                if (sample !== oldest_word.sample)
                begin
                    $display("%0t: sample expected %0d actual %0d",
                             $time, oldest_word.sample, sample);
                    error_count++;
                end
                if (last_sample !== oldest_word.last_sample)
                begin
                    $display("%0t: last_sample expected %0b actual %0b",
                             $time, oldest_word.last_sample, last_sample);
                    error_count++;
                end
                if (type_error !== oldest_word.type_error)
                begin
                    $display("%0t: type_error expected %0b actual %0b",
                             $time, oldest_word.type_error, type_error);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t dir_rows [$];
        int        rand_ticks;
        int        run_len;

        // Directed sequence: reset state, every wave, extremes and the corner cases.
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(reg_row(REG_WAVE_TYPE, 32'(SHAPE_SQUARE)));
        dir_rows.push_back(known_row(1'b0, POS_FULL_SCALE, 1'b1, 1'b0));
        dir_rows.push_back(reg_row(REG_PHASE_STEP, 32'h8000_0000));
        dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 32'd2));
        dir_rows.push_back(known_row(1'b1, POS_FULL_SCALE, 1'b0, 1'b0));
        dir_rows.push_back(known_row(1'b0, NEG_FULL_SCALE, 1'b1, 1'b0));
        dir_rows.push_back(known_row(1'b0, POS_FULL_SCALE, 1'b0, 1'b0));
        dir_rows.push_back(reg_row(REG_WAVE_TYPE, 32'(SHAPE_SAWTOOTH)));
        dir_rows.push_back(known_row(1'b1, NEG_FULL_SCALE, 1'b0, 1'b0));
        dir_rows.push_back(known_row(1'b0, 16'sd0, 1'b1, 1'b0));
        dir_rows.push_back(reg_row(REG_WAVE_TYPE, 32'(SHAPE_TRIANGLE)));
        dir_rows.push_back(reg_row(REG_PHASE_STEP, 32'h4000_0000));
        dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 32'd4));
        dir_rows.push_back(known_row(1'b1, 16'sd0, 1'b0, 1'b0));
        dir_rows.push_back(known_row(1'b0, POS_FULL_SCALE, 1'b0, 1'b0));
        dir_rows.push_back(known_row(1'b0, 16'sd0, 1'b0, 1'b0));
        dir_rows.push_back(known_row(1'b0, NEG_FULL_SCALE, 1'b1, 1'b0));
        // Unknown wave codes are silent and flagged.
        dir_rows.push_back(reg_row(REG_WAVE_TYPE, 32'(SHAPE_SILENT_FIRST)));
        dir_rows.push_back(known_row(1'b0, 16'sd0, 1'b0, 1'b1));
        dir_rows.push_back(reg_row(REG_WAVE_TYPE, 32'(SHAPE_SILENT_LAST)));
        dir_rows.push_back(known_row(1'b0, 16'sd0, 1'b0, 1'b1));
        // Noise: a zero seed loads one, and the most negative value is clamped.
        dir_rows.push_back(reg_row(REG_WAVE_TYPE, 32'(SHAPE_NOISE)));
        dir_rows.push_back(reg_row(REG_NOISE_SEED, 32'd0));
        dir_rows.push_back(known_row(1'b1, 16'sd0, 1'b0, 1'b0));
        dir_rows.push_back(reg_row(REG_NOISE_SEED, 32'h8000_0000));
        dir_rows.push_back(known_row(1'b1, NEG_FULL_SCALE, 1'b0, 1'b0));
        dir_rows.push_back(reg_row(REG_NOISE_SEED, 32'h7FFF_FFFF));
        dir_rows.push_back(known_row(1'b1, POS_FULL_SCALE, 1'b0, 1'b0));
        dir_rows.push_back(reg_row(REG_NOISE_SEED, 32'hFFFF_FFFF));
        dir_rows.push_back(tick_row(1'b1));
        // Largest step and count, then a count lowered below the running index, then zero.
        dir_rows.push_back(reg_row(REG_WAVE_TYPE, 32'(SHAPE_SINE)));
        dir_rows.push_back(reg_row(REG_PHASE_STEP, 32'hFFFF_FFFF));
        dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 32'h00FF_FFFF));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 32'd2));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 32'd0));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(tick_row(1'b1));

        rand_ticks = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg)
            begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            else
                send_tick(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].word);
        end

        // Random phases: new register settings between runs of ticks; no idling at the end.
        while (rand_ticks < RANDOM_TICKS)
        begin
            idle_on = (rand_ticks < RANDOM_TICKS - 150);
            settle();
            if ($urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 3) == 0)
                    write_reg(REG_WAVE_TYPE,
                              32'($urandom_range(32'(SHAPE_SINE), 32'(SHAPE_SILENT_LAST))));
                else
                    write_reg(REG_WAVE_TYPE,
                              32'($urandom_range(32'(SHAPE_SINE), 32'(SHAPE_NOISE))));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_PHASE_STEP, 32'd0);
                    1:       write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
                    2:       write_reg(REG_PHASE_STEP, 32'h8000_0000 >> $urandom_range(0, 31));
                    default: write_reg(REG_PHASE_STEP, $urandom);
                endcase
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 7))
                    0:       write_reg(REG_SAMPLE_COUNT, 32'd1);
                    1:       write_reg(REG_SAMPLE_COUNT, 32'h00FF_FFFF);
                    2:       write_reg(REG_SAMPLE_COUNT, $urandom_range(1, 32'h00FF_FFFF));
                    default: write_reg(REG_SAMPLE_COUNT, $urandom_range(2, 40));
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_NOISE_SEED, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);

            run_len = $urandom_range(20, 80);
            for (int n = 0; n < run_len; n++)
            begin
                if (n == 0)
                    send_tick($urandom_range(0, 1) == 1, 1'b0, rsp_t'(0));
                else
                    send_tick($urandom_range(0, 19) == 0, 1'b0, rsp_t'(0));
                rand_ticks++;
            end
        end

        settle();
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
